@@ rtl/tcfe_pkg.sv @@
// Package with beat types and constants for the transponder frame encoder.
package tcfe_pkg;

   // Field widths and frame geometry
   localparam int unsigned TX_W        = 27;
   localparam int unsigned GHOST_W     = 9;
   localparam int unsigned LAST_W      = 8;
   localparam int unsigned STREAM_LEN  = 36;
   localparam int unsigned REG_W       = STREAM_LEN + 1;
   localparam int unsigned HDR_BYTES   = 3;
   localparam int unsigned CODED_BYTES = 9;
   localparam int unsigned FRAME_LEN   = HDR_BYTES + CODED_BYTES;
   localparam int unsigned IDX_W       = 4;

   // Generator taps and header bytes
   localparam logic [REG_W-1:0] POLYNOMIAL = 37'h10_00EE_C20F;
   localparam logic [7:0]       HDR0       = 8'h00;
   localparam logic [7:0]       HDR1       = 8'hF9;
   localparam logic [7:0]       HDR2       = 8'h16;

   localparam logic [IDX_W-1:0] IDX_HDR0 = 4'd0;
   localparam logic [IDX_W-1:0] IDX_HDR1 = 4'd1;
   localparam logic [IDX_W-1:0] IDX_HDR2 = 4'd2;
   localparam logic [IDX_W-1:0] IDX_LAST = 4'(FRAME_LEN - 1);

   // Request beat
   typedef struct packed {
      logic [TX_W-1:0]    tx_number;
      logic [GHOST_W-1:0] ghost_bits;
      logic [LAST_W-1:0]  last_byte;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [7:0]       frame_byte;
      logic [IDX_W-1:0] byte_index;
      logic             last_of_frame;
   } rsp_type;

endpackage

@@ rtl/transponder_conv_frame_encoder.sv @@
// Top level of the transponder frame encoder: input register, encoder, frame register.
// A request beat waits in the input register and is encoded as it loads into the frame register.
// Each frame is twelve bytes long and leaves through the one-byte output port, which sets the frame rate.
// A new request is taken while the current frame still drains, so frames follow back to back.
// Reset clears the valid flags and the byte counter; payload registers are not reset.
module transponder_conv_frame_encoder
   import tcfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   // Input register
   logic    in_vld_ff, in_vld_in;
   req_type in_ff, in_in;

   // Frame register and byte counter
   logic                            frame_vld_ff, frame_vld_in;
   logic [CODED_BYTES-1:0][7:0]     coded_ff, coded_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;

   // Encoder signals
   logic [TX_W-1:0]       word;
   logic [REG_W-1:0]      stream;
   logic [2*STREAM_LEN-1:0] coded_bits;
   logic [CODED_BYTES-1:0][7:0] coded_next;
   logic                  req_fire, rsp_fire, frame_done, load;
   logic [IDX_W-1:0]      coded_sel;

   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign frame_done = rsp_fire && (idx_ff == IDX_LAST);
   assign load       = in_vld_ff && (!frame_vld_ff || frame_done);
   assign req_ready  = !in_vld_ff || load;

   // Build the interleaved stream; stream bit 0 is the last-built bit, bit 36 is the flush zero.
   always_comb begin
      word   = in_ff.tx_number | {in_ff.last_byte[2:0], 24'd0};
      stream = '0;
      for (int i = 0; i < STREAM_LEN; i++) begin
         if ((i % 4) != 3) begin
            stream[STREAM_LEN-1-i] = word[TX_W-1-(i - i/4)];
         end else begin
            stream[STREAM_LEN-1-i] = in_ff.ghost_bits[GHOST_W-1-(i/4)];
         end
      end
   end

   // Each shift k sees the stream bits 0..k in reverse; all 36 shifts are formed in parallel.
   always_comb begin
      logic [REG_W-1:0] sr;
      logic             p;
      coded_bits = '0;
      for (int k = 1; k <= STREAM_LEN; k++) begin
         sr = '0;
         for (int j = 0; j <= k; j++) begin
            sr[j] = stream[k-j];
         end
         p = ^(sr & POLYNOMIAL);
         coded_bits[2*STREAM_LEN-1-2*(k-1)] = p;
         coded_bits[2*STREAM_LEN-2-2*(k-1)] = p ^ sr[1];
      end
      for (int m = 0; m < CODED_BYTES; m++) begin
         coded_next[m] = coded_bits[2*STREAM_LEN-1-8*m -: 8];
      end
   end

   // Next-state logic for both register stages
   always_comb begin
      in_vld_in    = in_vld_ff;
      in_in        = in_ff;
      frame_vld_in = frame_vld_ff;
      coded_in     = coded_ff;
      idx_in       = idx_ff;
      if (load) begin
         in_vld_in = 1'b0;
      end
      if (req_fire) begin
         in_vld_in = 1'b1;
         in_in     = req_payload;
      end
      if (rsp_fire) begin
         if (frame_done) begin
            idx_in       = '0;
            frame_vld_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (load) begin
         frame_vld_in = 1'b1;
         coded_in     = coded_next;
         idx_in       = '0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         frame_vld_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         in_vld_ff    <= in_vld_in;
         frame_vld_ff <= frame_vld_in;
         idx_ff       <= idx_in;
      end
      in_ff    <= in_in;
      coded_ff <= coded_in;
   end

   // Output byte selection: header first, then coded bytes.
   assign coded_sel = idx_ff - 4'(HDR_BYTES);

   always_comb begin
      rsp_payload.byte_index    = idx_ff;
      rsp_payload.last_of_frame = (idx_ff == IDX_LAST);
      case (idx_ff)
         IDX_HDR0: rsp_payload.frame_byte = HDR0;
         IDX_HDR1: rsp_payload.frame_byte = HDR1;
         IDX_HDR2: rsp_payload.frame_byte = HDR2;
         default: begin
            if (coded_sel < 4'(CODED_BYTES)) begin
               rsp_payload.frame_byte = coded_ff[coded_sel];
            end else begin
               rsp_payload.frame_byte = '0;
            end
         end
      endcase
   end

   assign rsp_valid = frame_vld_ff;

endmodule

@@ verif/tb_transponder_conv_frame_encoder.sv @@
// Self-checking testbench for the transponder convolutional frame encoder.
module tb_transponder_conv_frame_encoder;
   import tcfe_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 150;
   localparam int unsigned TAIL_CYCLES    = 16;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned IDLE_MAX       = 6;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   // Frame bytes predicted for accepted requests, oldest first.
   rsp_type     frame_bytes_due[$];
   rsp_type     due_beat;
   int unsigned mismatch_count;
   int unsigned idle_cycles;
   int unsigned sender_idle_max;
   int unsigned receiver_idle_max;
   int unsigned rsp_hold_cycles;

   transponder_conv_frame_encoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Free-running clock with a period of 8.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Counts a failure and prints the first few of them.
   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   // Works out the twelve bytes of the frame for one request and queues them.
   function automatic void encode_frame(input req_type r);
      logic [TX_W-1:0]       word;
      logic [STREAM_LEN-1:0] stream;
      logic [STREAM_LEN-1:0] rest;
      logic [REG_W-1:0]      shreg;
      logic [7:0]            acc;
      logic                  p;
      logic                  q;
      logic [IDX_W-1:0]      idx;
      int                    dpos;
      int                    gpos;
      int                    i;
      rsp_type               beat;

      // Only the low three bits of the last byte fit into the 27-bit word.
      word = r.tx_number | (TX_W'(r.last_byte[2:0]) << 24);

      // Three word bits, then one ghost bit; the first bit built is the MSB.
      dpos = TX_W;
      gpos = GHOST_W;
      for (i = 0; i < STREAM_LEN; i++) begin
         if ((i % 4) != 3) begin
            dpos--;
            stream[STREAM_LEN-1-i] = word[dpos];
         end else begin
            gpos--;
            stream[STREAM_LEN-1-i] = r.ghost_bits[gpos];
         end
      end

      // Fixed header bytes.
      beat.frame_byte    = HDR0;
      beat.byte_index    = IDX_HDR0;
      beat.last_of_frame = 1'b0;
      frame_bytes_due.push_back(beat);
      beat.frame_byte    = HDR1;
      beat.byte_index    = IDX_HDR1;
      frame_bytes_due.push_back(beat);
      beat.frame_byte    = HDR2;
      beat.byte_index    = IDX_HDR2;
      frame_bytes_due.push_back(beat);

      // The register starts with the last stream bit; the final shift flushes in a zero.
      shreg = REG_W'(stream[0]);
      rest  = stream >> 1;
      acc   = 8'h00;
      idx   = IDX_W'(HDR_BYTES);
      for (i = 0; i < STREAM_LEN; i++) begin
         shreg = {shreg[REG_W-2:0], rest[0]};
         rest  = rest >> 1;
         p     = ^(shreg & POLYNOMIAL);
         q     = p ^ shreg[1];
         acc   = {acc[5:0], p, q};
         if ((i % 4) == 3) begin
            beat.frame_byte    = acc;
            beat.byte_index    = idx;
            beat.last_of_frame = (idx == IDX_LAST);
            frame_bytes_due.push_back(beat);
            idx = idx + 1'b1;
            acc = 8'h00;
         end
      end
   endfunction

   // Offers one request after a random gap and holds it until it is taken.
   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = $urandom_range(0, sender_idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      encode_frame(r);
   endtask

   task automatic send_fields(input logic [TX_W-1:0] tx, input logic [GHOST_W-1:0] ghost,
                              input logic [LAST_W-1:0] last);
      req_type r;
      r.tx_number  = tx;
      r.ghost_bits = ghost;
      r.last_byte  = last;
      send_request(r);
   endtask

   function automatic req_type random_request();
      req_type r;
      r.tx_number  = TX_W'($urandom);
      r.ghost_bits = GHOST_W'($urandom);
      // Half the time keep the last byte small so it lands inside the word.
      if ($urandom_range(0, 1) == 0) begin
         r.last_byte = LAST_W'($urandom_range(0, 7));
      end else begin
         r.last_byte = LAST_W'($urandom);
      end
      return r;
   endfunction

   // Stops offering requests until every predicted byte has come back.
   task automatic wait_frames_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (frame_bytes_due.size() != 0);
   endtask

   // Field extremes, dropped high bits of the last byte and bit patterns.
   task automatic test_directed();
      sender_idle_max   = IDLE_MAX;
      receiver_idle_max = IDLE_MAX;
      send_fields(27'h0000000, 9'h000, 8'h00);
      send_fields(27'h7FFFFFF, 9'h1FF, 8'hFF);
      send_fields(27'h0000000, 9'h000, 8'hF8);
      send_fields(27'h0000000, 9'h000, 8'h07);
      send_fields(27'h0000000, 9'h000, 8'h01);
      send_fields(27'h0FFFFFF, 9'h000, 8'h00);
      send_fields(27'h7FFFFFF, 9'h000, 8'h00);
      send_fields(27'h0000000, 9'h1FF, 8'h00);
      send_fields(27'h0000000, 9'h100, 8'h00);
      send_fields(27'h0000000, 9'h001, 8'h00);
      send_fields(27'h0000001, 9'h000, 8'h00);
      send_fields(27'h4000000, 9'h000, 8'h00);
      send_fields(27'h5555555, 9'h0AA, 8'h55);
      send_fields(27'h2AAAAAA, 9'h155, 8'hAA);
      send_fields(27'h7000000, 9'h000, 8'hF8);
      send_fields(27'h0123456, 9'h0C3, 8'h03);
      wait_frames_drained();
   endtask

   // Requests and results with no idling on either side.
   task automatic test_back_to_back();
      int i;
      sender_idle_max   = 0;
      receiver_idle_max = 0;
      for (i = 0; i < 20; i++) begin
         send_request(random_request());
      end
      receiver_idle_max = IDLE_MAX;
   endtask

   // The receiver holds off for a long stretch so the block stalls its input.
   task automatic test_output_stall();
      int i;
      wait_frames_drained();
      sender_idle_max = 0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (i = 0; i < 10; i++) begin
         send_request(random_request());
      end
   endtask

   // Random requests with random idling, and a full drain halfway through.
   task automatic test_random();
      int i;
      sender_idle_max   = IDLE_MAX;
      receiver_idle_max = IDLE_MAX;
      for (i = 0; i < 80; i++) begin
         if (i == 40) begin
            wait_frames_drained();
         end
         send_request(random_request());
      end
   endtask

   // Receiver: random stalls before each beat, plus an occasional long hold-off.
   initial begin
      int unsigned gap;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         gap = $urandom_range(0, receiver_idle_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compares every accepted frame byte with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            note_failure($sformatf("unexpected beat byte %02h index %0d last %0b",
                                   rsp_payload.frame_byte, rsp_payload.byte_index,
                                   rsp_payload.last_of_frame));
         end else begin
            due_beat = frame_bytes_due.pop_front();
            if (rsp_payload.frame_byte !== due_beat.frame_byte) begin
               note_failure($sformatf("frame_byte at index %0d: expected %02h, got %02h",
                                      due_beat.byte_index, due_beat.frame_byte,
                                      rsp_payload.frame_byte));
            end
            if (rsp_payload.byte_index !== due_beat.byte_index) begin
               note_failure($sformatf("byte_index: expected %0d, got %0d",
                                      due_beat.byte_index, rsp_payload.byte_index));
            end
            if (rsp_payload.last_of_frame !== due_beat.last_of_frame) begin
               note_failure($sformatf("last_of_frame at index %0d: expected %0b, got %0b",
                                      due_beat.byte_index, due_beat.last_of_frame,
                                      rsp_payload.last_of_frame));
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_payload       = '0;
      mismatch_count    = 0;
      idle_cycles       = 0;
      rsp_hold_cycles   = 0;
      sender_idle_max   = IDLE_MAX;
      receiver_idle_max = IDLE_MAX;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_back_to_back();
      test_output_stall();
      test_random();

      // Let the last frames drain, then give the block a few more cycles.
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tcfe_pkg.sv
rtl/transponder_conv_frame_encoder.sv
verif/tb_transponder_conv_frame_encoder.sv
